>>> hw/rtl/nqfs_pkg.sv
// Package for the n-queens first-solution search block.
// Holds field widths, the controller state type and the command/status structs.
// No dependencies.
package nqfs_pkg;

  localparam int MAX_N_DEFAULT = 16;
  localparam int BOARD_SIZE_W  = 5;
  localparam int INDEX_OUT_W   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RESTORE,
    ST_EMIT_READ,
    ST_EMIT_WRITE,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic start;
    logic place;
    logic skip;
    logic retreat;
    logic restore;
    logic emit_init;
    logic emit_load;
    logic emit_next;
    logic fail_load;
  } cmd_t;

  typedef struct packed {
    logic cols_full;
    logic rows_spent;
    logic col_zero;
    logic square_free;
    logic out_free;
    logic emit_last;
    logic req_bad;
  } status_t;

endpackage

>>> hw/rtl/nqfs_req_if.sv
// Request channel of the n-queens search: valid/ready plus board size.
// Depends on nqfs_pkg.
interface nqfs_req_if;
  import nqfs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BOARD_SIZE_W-1:0] board_size;

  modport source (output valid, output board_size, input ready);
  modport sink (input valid, input board_size, output ready);
endinterface

>>> hw/rtl/nqfs_res_if.sv
// Result channel of the n-queens search: valid/ready plus one column result.
// Depends on nqfs_pkg.
interface nqfs_res_if;
  import nqfs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [INDEX_OUT_W-1:0] column_index;
  logic [INDEX_OUT_W-1:0] queen_row;
  logic                   found;
  logic                   last;

  modport source (output valid, output column_index, output queen_row, output found,
                  output last, input ready);
  modport sink (input valid, input column_index, input queen_row, input found,
                input last, output ready);
endinterface

>>> hw/rtl/nqfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nqfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/nqfs_datapath.sv
// Datapath of the n-queens search: counters, occupancy masks, row stack, result register.
// Depends on nqfs_pkg, nqfs_res_if and nqfs_ram.
module nqfs_datapath #(
  parameter int MAX_N = nqfs_pkg::MAX_N_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [nqfs_pkg::BOARD_SIZE_W-1:0]   board_size,
  input  nqfs_pkg::cmd_t                      cmd,
  output nqfs_pkg::status_t                   status,
  nqfs_res_if.source                          res
);
  import nqfs_pkg::*;

  localparam int COL_W  = $clog2(MAX_N + 1);
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int DIAG_N = 2 * MAX_N - 1;
  localparam int DIAG_W = $clog2(DIAG_N);

  logic [COL_W-1:0]  n_size;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic [MAX_N-1:0]  row_mask;
  logic [DIAG_N-1:0] rise_mask;
  logic [DIAG_N-1:0] fall_mask;

  logic [IDX_W-1:0]  col_i;
  logic [IDX_W-1:0]  row_i;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_data;
  logic [IDX_W-1:0]  flip_row;
  logic [DIAG_W-1:0] rise_idx;
  logic [DIAG_W-1:0] fall_idx;

  logic                   out_valid;
  logic [INDEX_OUT_W-1:0] out_column;
  logic [INDEX_OUT_W-1:0] out_row;
  logic                   out_found;
  logic                   out_last;

  assign col_i    = col[IDX_W-1:0];
  assign row_i    = row[IDX_W-1:0];
  assign rd_addr  = cmd.retreat ? (col_i - IDX_W'(1)) : col_i;
  assign flip_row = cmd.restore ? rd_data : row_i;
  assign rise_idx = DIAG_W'(flip_row) + DIAG_W'(col_i);
  assign fall_idx = DIAG_W'(flip_row) + DIAG_W'(MAX_N - 1) - DIAG_W'(col_i);

  nqfs_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_N)
  ) u_stack (
    .clk     (clk),
    .we      (cmd.place),
    .wr_addr (col_i),
    .wr_data (row_i),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    status.cols_full   = (col >= n_size);
    status.rows_spent  = (row >= n_size);
    status.col_zero    = (col == '0);
    status.square_free = !row_mask[row_i] && !rise_mask[rise_idx] && !fall_mask[fall_idx];
    status.out_free    = !out_valid || res.ready;
    status.emit_last   = ((col + COL_W'(1)) == n_size);
    status.req_bad     = (board_size == '0) || (int'(board_size) > MAX_N);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_size    <= '0;
      col       <= '0;
      row       <= '0;
      row_mask  <= '0;
      rise_mask <= '0;
      fall_mask <= '0;
    end else begin
      if (cmd.start) begin
        n_size    <= COL_W'(board_size);
        col       <= '0;
        row       <= '0;
        row_mask  <= '0;
        rise_mask <= '0;
        fall_mask <= '0;
      end
      if (cmd.place || cmd.restore) begin
        row_mask  <= row_mask ^ (MAX_N'(1) << flip_row);
        rise_mask <= rise_mask ^ (DIAG_N'(1) << rise_idx);
        fall_mask <= fall_mask ^ (DIAG_N'(1) << fall_idx);
      end
      if (cmd.place) begin
        col <= col + COL_W'(1);
        row <= '0;
      end
      if (cmd.skip) begin
        row <= row + COL_W'(1);
      end
      if (cmd.retreat) begin
        col <= col - COL_W'(1);
      end
      if (cmd.restore) begin
        row <= COL_W'(rd_data) + COL_W'(1);
      end
      if (cmd.emit_init) begin
        col <= '0;
      end
      if (cmd.emit_next) begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.fail_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_column <= INDEX_OUT_W'(col);
      out_row    <= INDEX_OUT_W'(rd_data);
      out_found  <= 1'b1;
      out_last   <= status.emit_last;
    end else if (cmd.fail_load) begin
      out_column <= '0;
      out_row    <= '0;
      out_found  <= 1'b0;
      out_last   <= 1'b1;
    end
  end

  assign res.valid        = out_valid;
  assign res.column_index = out_column;
  assign res.queen_row    = out_row;
  assign res.found        = out_found;
  assign res.last         = out_last;

endmodule

>>> hw/rtl/nqfs_ctrl.sv
// Controller of the n-queens search: sequences search steps, backtracking and emission.
// Depends on nqfs_pkg.
module nqfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output nqfs_pkg::cmd_t    cmd,
  input  nqfs_pkg::status_t status
);
  import nqfs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = status.req_bad ? ST_FAIL : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.cols_full) begin
          state_next = ST_EMIT_READ;
        end else if (status.rows_spent) begin
          state_next = status.col_zero ? ST_FAIL : ST_RESTORE;
        end
      end
      ST_RESTORE:   state_next = ST_CHECK;
      ST_EMIT_READ: state_next = ST_EMIT_WRITE;
      ST_EMIT_WRITE: begin
        if (status.out_free) begin
          state_next = status.emit_last ? ST_IDLE : ST_EMIT_READ;
        end
      end
      ST_FAIL: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.start = req_valid && !status.req_bad;
      end
      ST_CHECK: begin
        if (status.cols_full) begin
          cmd.emit_init = 1'b1;
        end else if (status.rows_spent) begin
          cmd.retreat = !status.col_zero;
        end else if (status.square_free) begin
          cmd.place = 1'b1;
        end else begin
          cmd.skip = 1'b1;
        end
      end
      ST_RESTORE: cmd.restore = 1'b1;
      ST_EMIT_READ: ;
      ST_EMIT_WRITE: begin
        cmd.emit_load = status.out_free;
        cmd.emit_next = status.out_free && !status.emit_last;
      end
      ST_FAIL: cmd.fail_load = status.out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/n_queens_first_solution_top.sv
// Top level of the n-queens first-solution search block.
// Depends on nqfs_pkg, nqfs_req_if, nqfs_res_if, nqfs_ctrl and nqfs_datapath.
//
// A request carries a board size n; the block runs a depth-first backtracking search
// (columns left to right, rows ascending) and returns one result per column with the
// queen's row, last set on the final column, or a single result with found = 0 when
// n is zero, above MAX_N, or has no placement. Each trial placement or row skip is
// one CHECK step; a backtrack passes through CHECK and RESTORE (the row stack RAM has a
// registered read), and each emitted column through EMIT_READ and EMIT_WRITE plus any
// stall on the result side; a new request is taken once the previous one has been
// handed to the result register. Search time grows with the number of trials.
module n_queens_first_solution_top #(
  parameter int MAX_N = nqfs_pkg::MAX_N_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  nqfs_req_if.sink   req,
  nqfs_res_if.source res
);
  import nqfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  nqfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .status    (status)
  );

  nqfs_datapath #(
    .MAX_N(MAX_N)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .board_size (req.board_size),
    .cmd        (cmd),
    .status     (status),
    .res        (res)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a search was still open");

  a_single_move: assert property (@(posedge clk) disable iff (rst)
    !(cmd.place && cmd.retreat) && !(cmd.place && cmd.skip) && !(cmd.retreat && cmd.skip))
    else $error("conflicting search moves in one cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load || cmd.fail_load |-> status.out_free)
    else $error("result register overwritten before it was taken");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.found |-> res.last)
    else $error("failure result without last");

endmodule

>>> test/n_queens_first_solution_top_test.sv
`timescale 1ns / 100ps
// Testbench for n_queens_first_solution_top: board-size requests in, per-column placements out.
// Depends on nqfs_pkg, nqfs_req_if, nqfs_res_if and the block itself; results are checked
// against table answers or an in-bench backtracking search, directed table then random sizes.
module n_queens_first_solution_top_test;
  import nqfs_pkg::*;

  localparam int MAX_N          = MAX_N_DEFAULT;
  localparam int RANDOM_BOARDS  = 118;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES   = 32;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] column_index;
    logic [INDEX_OUT_W-1:0] queen_row;
    logic                   found;
    logic                   last;
  } placement_t;

  typedef struct {
    logic [BOARD_SIZE_W-1:0] size;
    bit                      typed;
    placement_t              answer;
  } board_row_t;

  localparam placement_t NO_PLACEMENT = '{4'd0, 4'd0, 1'b0, 1'b1};
  localparam placement_t LONE_QUEEN   = '{4'd0, 4'd0, 1'b1, 1'b1};

  board_row_t board_table [22] = '{
    '{5'd0,  1'b1, NO_PLACEMENT},
    '{5'd1,  1'b1, LONE_QUEEN},
    '{5'd2,  1'b1, NO_PLACEMENT},
    '{5'd3,  1'b1, NO_PLACEMENT},
    '{5'd17, 1'b1, NO_PLACEMENT},
    '{5'd31, 1'b1, NO_PLACEMENT},
    '{5'd4,  1'b0, NO_PLACEMENT},
    '{5'd5,  1'b0, NO_PLACEMENT},
    '{5'd6,  1'b0, NO_PLACEMENT},
    '{5'd7,  1'b0, NO_PLACEMENT},
    '{5'd8,  1'b0, NO_PLACEMENT},
    '{5'd9,  1'b0, NO_PLACEMENT},
    '{5'd10, 1'b0, NO_PLACEMENT},
    '{5'd16, 1'b0, NO_PLACEMENT},
    '{5'd24, 1'b1, NO_PLACEMENT},
    '{5'd15, 1'b0, NO_PLACEMENT},
    '{5'd14, 1'b0, NO_PLACEMENT},
    '{5'd13, 1'b0, NO_PLACEMENT},
    '{5'd12, 1'b0, NO_PLACEMENT},
    '{5'd11, 1'b0, NO_PLACEMENT},
    '{5'd1,  1'b1, LONE_QUEEN},
    '{5'd0,  1'b1, NO_PLACEMENT}
  };

  logic clk;
  logic rst;

  nqfs_req_if req_ch ();
  nqfs_res_if res_ch ();

  n_queens_first_solution_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  placement_t placement_q[$];
  int         error_count;
  int         boards_sent;
  int         results_seen;
  int         solved_boards;
  int         failed_boards;
  int         burst_left;
  int         idle_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Backtracking search at the block's widths; queue the placements it finds, or a no-placement result.
  task automatic predict_placement(input logic [BOARD_SIZE_W-1:0] size);
    logic [MAX_N-1:0]   row_busy;
    logic [2*MAX_N-2:0] rise_busy;
    logic [2*MAX_N-2:0] fall_busy;
    int                 placed [MAX_N];
    int                 n;
    int                 col;
    int                 trial;
    int                 back;
    bit                 searching;
    bit                 solved;
    placement_t         entry;
    n      = size;
    solved = 1'b0;
    if (n >= 1 && n <= MAX_N) begin
      row_busy  = '0;
      rise_busy = '0;
      fall_busy = '0;
      col       = 0;
      trial     = 0;
      searching = 1'b1;
      while (searching) begin
        if (col >= n) begin
          solved    = 1'b1;
          searching = 1'b0;
        end else if (trial >= n) begin
          if (col == 0) begin
            searching = 1'b0;
          end else begin
            col--;
            back                          = placed[col];
            row_busy[back]                = 1'b0;
            rise_busy[back + col]         = 1'b0;
            fall_busy[back + MAX_N-1-col] = 1'b0;
            trial                         = back + 1;
          end
        end else if (!row_busy[trial] && !rise_busy[trial + col] &&
                     !fall_busy[trial + MAX_N-1-col]) begin
          placed[col]                    = trial;
          row_busy[trial]                = 1'b1;
          rise_busy[trial + col]         = 1'b1;
          fall_busy[trial + MAX_N-1-col] = 1'b1;
          col++;
          trial = 0;
        end else begin
          trial++;
        end
      end
    end
    if (solved) begin
      for (int c = 0; c < n; c++) begin
        entry.column_index = INDEX_OUT_W'(c);
        entry.queen_row    = INDEX_OUT_W'(placed[c]);
        entry.found        = 1'b1;
        entry.last         = (c == n - 1);
        placement_q.push_back(entry);
      end
    end else begin
      placement_q.push_back(NO_PLACEMENT);
    end
  endtask

  task automatic offer_board(input logic [BOARD_SIZE_W-1:0] size, input bit typed,
                             input placement_t answer);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    req_ch.valid      <= 1'b1;
    req_ch.board_size <= size;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (typed) placement_q.push_back(answer);
    else predict_placement(size);
    boards_sent++;
    burst_left--;
  endtask

  task automatic wait_for_results;
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BOARD_SIZE_W-1:0] pick_board_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 10) return BOARD_SIZE_W'($urandom_range(MAX_N + 1, 31));
    if (roll < 13) return BOARD_SIZE_W'($urandom_range(13, MAX_N));
    return BOARD_SIZE_W'($urandom_range(1, 12));
  endfunction

  // Result side: check each accepted result, then pick the next ready value.
  initial begin : result_sink
    int         stall_mode;
    int         mode_left;
    int         tick;
    placement_t got;
    placement_t want;
    res_ch.ready = 1'b0;
    stall_mode   = 0;
    mode_left    = 0;
    tick         = 0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.column_index, res_ch.queen_row, res_ch.found, res_ch.last};
        results_seen++;
        if (got.last && got.found) solved_boards++;
        if (got.last && !got.found) failed_boards++;
        if (placement_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result col %0d row %0d found %0b last %0b",
                   $time, got.column_index, got.queen_row, got.found, got.last);
        end else begin
          want = placement_q.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: mismatch, expected c%0d r%0d f%0b l%0b, got c%0d r%0d f%0b l%0b",
                     $time, want.column_index, want.queen_row, want.found, want.last,
                     got.column_index, got.queen_row, got.found, got.last);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      tick++;
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= $urandom_range(0, 1);
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (tick % 8 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.board_size = '0;
    error_count       = 0;
    boards_sent       = 0;
    results_seen      = 0;
    solved_boards     = 0;
    failed_boards     = 0;
    burst_left        = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (board_table[i])
      offer_board(board_table[i].size, board_table[i].typed, board_table[i].answer);
    wait_for_results();

    for (int i = 0; i < RANDOM_BOARDS; i++) begin
      if (i == RANDOM_BOARDS / 2) wait_for_results();
      offer_board(pick_board_size(), 1'b0, NO_PLACEMENT);
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d board requests: %0d solved, %0d without placement or invalid.",
             boards_sent, solved_boards, failed_boards);
    $display("Checked %0d result items with %0d mismatches.", results_seen, error_count);
    if (error_count == 0 && placement_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0t: %0d expected results never arrived", $time, placement_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
